// ===== design/sdz_pkg.sv =====
// Package for the stick radial deadzone block.
// Request and response payload types and fixed-point constants.
// No dependencies.
`default_nettype none
package sdz_pkg;
	localparam logic [14:0] UNITY = 15'h7FFF;
	localparam logic [15:0] DZ_RESET = 16'd15729;
	localparam int ROOT_BITS = 24;
	localparam int Q_BITS = 15;

	typedef struct packed {
		logic signed [15:0] stick_x;
		logic signed [15:0] stick_y;
	} req_t;

	typedef struct packed {
		logic signed [15:0] out_x;
		logic signed [15:0] out_y;
		logic [14:0] out_magnitude;
		logic in_deadzone;
	} rsp_t;
endpackage
`default_nettype wire

// ===== design/stick_radial_deadzone.sv =====
// Stick radial deadzone: fully pipelined conditioning of one thumbstick sample.
// Depends on sdz_pkg for payload types and constants.
//
// One request per cycle while the response is not stalled. The pipeline holds the
// 24-stage square root and the two 15-stage restoring dividers (magnitude
// rescale, then axis scaling). A stalled response holds the whole
// pipeline; no request is lost or repeated. deadzone_fraction is written through
// cfg_we/cfg_wdata and must only change while the pipeline is empty.
`default_nettype none
module stick_radial_deadzone #(
	parameter int AXIS_BITS = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire sdz_pkg::req_t  req,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output sdz_pkg::rsp_t       rsp,
	input  wire logic           cfg_we,
	input  wire logic [15:0]    cfg_wdata
);
	localparam int RB = sdz_pkg::ROOT_BITS;
	localparam int QB = sdz_pkg::Q_BITS;
	localparam int LAT = 7 + RB + 1 + QB + 2 + QB + 1;
	localparam int FS = (1 << (AXIS_BITS - 1)) - 1;
	localparam logic [16:0] FS17 = 17'(FS);
	localparam logic [15:0] FS16 = 16'(FS);
	localparam logic [29:0] FS30 = 30'(FS);
	localparam logic [25:0] RECIP = 26'((64'd1 << 32) / 64'(FS));

	typedef struct packed {
		logic [1:0][14:0] n;
		logic [1:0]       neg;
		logic             dead;
		logic             zero;
		logic [23:0]      s;
		logic [14:0]      om;
		logic             osat;
		logic [1:0]       asat;
	} item_t;

	logic [15:0] dz_q;
	logic [LAT-1:0] vld_q;
	logic adv;

	assign adv = ~vld_q[LAT-1] | rsp_ready;
	assign req_ready = adv;
	assign rsp_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dz_q <= sdz_pkg::DZ_RESET;
			vld_q <= '0;
		end else begin
			if (cfg_we) begin
				dz_q <= cfg_wdata;
			end
			if (adv) begin
				vld_q <= {vld_q[LAT-2:0], req_valid};
			end
		end
	end

	// clamp to full scale, take magnitude, times 32767
	logic [1:0][15:0] raw_c;
	logic [1:0][16:0] abs_c;
	logic [1:0][14:0] mag_c;
	logic [1:0][29:0] p_c;
	assign raw_c[0] = req.stick_x;
	assign raw_c[1] = req.stick_y;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			abs_c[l] = raw_c[l][15] ? (~{1'b1, raw_c[l]}) + 17'd1 : {1'b0, raw_c[l]};
			mag_c[l] = (abs_c[l] > FS17) ? FS17[14:0] : abs_c[l][14:0];
			p_c[l] = {mag_c[l], 15'd0} - {15'd0, mag_c[l]};
		end
	end

	logic [1:0][29:0] p_s1;
	logic [1:0] neg_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1 <= p_c;
			neg_s1 <= {raw_c[1][15], raw_c[0][15]};
		end
	end

	// divide by full scale: reciprocal estimate, then one correction
	logic [1:0][55:0] prod2_c;
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			prod2_c[l] = 56'(p_s1[l]) * 56'(RECIP);
		end
	end

	logic [1:0][15:0] q0_s2;
	logic [1:0][29:0] p_s2;
	logic [1:0] neg_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			q0_s2 <= {prod2_c[1][47:32], prod2_c[0][47:32]};
			p_s2 <= p_s1;
			neg_s2 <= neg_s1;
		end
	end

	logic [1:0][31:0] t_c;
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			t_c[l] = 32'(q0_s2[l]) * 32'(FS16);
		end
	end

	logic [1:0][15:0] q0_s3;
	logic [1:0][29:0] t_s3;
	logic [1:0][29:0] p_s3;
	logic [1:0] neg_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			q0_s3 <= q0_s2;
			t_s3 <= {t_c[1][29:0], t_c[0][29:0]};
			p_s3 <= p_s2;
			neg_s3 <= neg_s2;
		end
	end

	item_t it4_c;
	always_comb begin
		it4_c = '0;
		it4_c.neg = neg_s3;
		for (int l = 0; l < 2; l++) begin
			it4_c.n[l] = q0_s3[l][14:0] + 15'((p_s3[l] - t_s3[l]) >= FS30);
		end
	end

	item_t it_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			it_s4 <= it4_c;
		end
	end

	// squares and deadzone threshold
	logic [30:0] thr_c;
	assign thr_c = {dz_q, 15'd0} - 31'(dz_q);

	logic [1:0][29:0] sq_s5;
	logic [30:0] thr_s5;
	item_t it_s5;
	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s5[0] <= 30'(it_s4.n[0]) * 30'(it_s4.n[0]);
			sq_s5[1] <= 30'(it_s4.n[1]) * 30'(it_s4.n[1]);
			thr_s5 <= thr_c;
			it_s5 <= it_s4;
		end
	end

	logic [30:0] m2_s6;
	logic [61:0] thr2_s6;
	item_t it_s6;
	always_ff @(posedge clk) begin
		if (adv) begin
			m2_s6 <= 31'(sq_s5[0]) + 31'(sq_s5[1]);
			thr2_s6 <= 62'(thr_s5) * 62'(thr_s5);
			it_s6 <= it_s5;
		end
	end

	item_t it7_c;
	always_comb begin
		it7_c = it_s6;
		it7_c.dead = {m2_s6, 32'd0} < {1'b0, thr2_s6};
	end

	logic [47:0] rem_s7;
	item_t it_s7;
	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s7 <= {1'b0, m2_s6, 16'd0};
			it_s7 <= it7_c;
		end
	end

	// square root of m2 * 65536, one result bit per stage
	logic [47:0] sq_rem_s [RB];
	logic [23:0] sq_root_s [RB];
	item_t sq_it_s [RB];

	for (genvar k = 0; k < RB; k++) begin : g_sqrt
		localparam int B = RB - 1 - k;
		logic [47:0] rem_in;
		logic [23:0] root_in;
		item_t it_in;
		logic [48:0] trial;
		if (k == 0) begin : g_first
			assign rem_in = rem_s7;
			assign root_in = '0;
			assign it_in = it_s7;
		end else begin : g_next
			assign rem_in = sq_rem_s[k-1];
			assign root_in = sq_root_s[k-1];
			assign it_in = sq_it_s[k-1];
		end
		assign trial = (49'(root_in) << (B + 1)) | (49'd1 << (2 * B));
		always_ff @(posedge clk) begin
			if (adv) begin
				sq_it_s[k] <= it_in;
				if ({1'b0, rem_in} >= trial) begin
					sq_rem_s[k] <= 48'({1'b0, rem_in} - trial);
					sq_root_s[k] <= root_in | (24'd1 << B);
				end else begin
					sq_rem_s[k] <= rem_in;
					sq_root_s[k] <= root_in;
				end
			end
		end
	end

	// rescale: (s*256 - 32767*dz) / (65536 - dz)
	logic [16:0] dsor_c;
	logic [23:0] s_c;
	logic [31:0] s256_c;
	logic [31:0] num_c;
	assign dsor_c = 17'h10000 - {1'b0, dz_q};
	assign s_c = sq_root_s[RB-1];
	assign s256_c = {s_c, 8'd0};
	assign num_c = (s256_c > 32'(thr_c)) ? s256_c - 32'(thr_c) : '0;

	item_t dv0_c;
	always_comb begin
		dv0_c = sq_it_s[RB-1];
		dv0_c.s = s_c;
		dv0_c.zero = (s_c == '0);
		dv0_c.osat = num_c >= {dsor_c, 15'd0};
	end

	logic [31:0] dv_rem_s0;
	item_t dv_it_s0;
	always_ff @(posedge clk) begin
		if (adv) begin
			dv_rem_s0 <= num_c;
			dv_it_s0 <= dv0_c;
		end
	end

	logic [31:0] dv_rem_s [QB];
	logic [14:0] dv_q_s [QB];
	item_t dv_it_s [QB];

	for (genvar k = 0; k < QB; k++) begin : g_omdiv
		localparam int B = QB - 1 - k;
		logic [31:0] rem_in;
		logic [14:0] q_in;
		item_t it_in;
		logic [31:0] dcmp;
		if (k == 0) begin : g_first
			assign rem_in = dv_rem_s0;
			assign q_in = '0;
			assign it_in = dv_it_s0;
		end else begin : g_next
			assign rem_in = dv_rem_s[k-1];
			assign q_in = dv_q_s[k-1];
			assign it_in = dv_it_s[k-1];
		end
		assign dcmp = 32'(dsor_c) << B;
		always_ff @(posedge clk) begin
			if (adv) begin
				dv_it_s[k] <= it_in;
				if (rem_in >= dcmp) begin
					dv_rem_s[k] <= rem_in - dcmp;
					dv_q_s[k] <= q_in | (15'd1 << B);
				end else begin
					dv_rem_s[k] <= rem_in;
					dv_q_s[k] <= q_in;
				end
			end
		end
	end

	// axis scaling: |n| * om * 256 / s
	logic [14:0] om_c;
	assign om_c = dv_it_s[QB-1].osat ? sdz_pkg::UNITY : dv_q_s[QB-1];

	item_t ma_c;
	always_comb begin
		ma_c = dv_it_s[QB-1];
		ma_c.om = om_c;
	end

	logic [1:0][29:0] ma_prod_s;
	item_t ma_it_s;
	always_ff @(posedge clk) begin
		if (adv) begin
			ma_prod_s[0] <= 30'(dv_it_s[QB-1].n[0]) * 30'(om_c);
			ma_prod_s[1] <= 30'(dv_it_s[QB-1].n[1]) * 30'(om_c);
			ma_it_s <= ma_c;
		end
	end

	item_t mb_c;
	always_comb begin
		mb_c = ma_it_s;
		for (int l = 0; l < 2; l++) begin
			mb_c.asat[l] = {1'b0, ma_prod_s[l], 8'd0} >= {ma_it_s.s, 15'd0};
		end
	end

	logic [1:0][37:0] mb_rem_s;
	item_t mb_it_s;
	always_ff @(posedge clk) begin
		if (adv) begin
			mb_it_s <= mb_c;
			for (int l = 0; l < 2; l++) begin
				mb_rem_s[l] <= {ma_prod_s[l], 8'd0};
			end
		end
	end

	logic [1:0][37:0] sc_rem_s [QB];
	logic [1:0][14:0] sc_q_s [QB];
	item_t sc_it_s [QB];

	for (genvar k = 0; k < QB; k++) begin : g_scdiv
		localparam int B = QB - 1 - k;
		logic [1:0][37:0] rem_in;
		logic [1:0][14:0] q_in;
		item_t it_in;
		logic [38:0] dcmp;
		if (k == 0) begin : g_first
			assign rem_in = mb_rem_s;
			assign q_in = '0;
			assign it_in = mb_it_s;
		end else begin : g_next
			assign rem_in = sc_rem_s[k-1];
			assign q_in = sc_q_s[k-1];
			assign it_in = sc_it_s[k-1];
		end
		assign dcmp = 39'(it_in.s) << B;
		always_ff @(posedge clk) begin
			if (adv) begin
				sc_it_s[k] <= it_in;
				for (int l = 0; l < 2; l++) begin
					if ({1'b0, rem_in[l]} >= dcmp) begin
						sc_rem_s[k][l] <= rem_in[l] - dcmp[37:0];
						sc_q_s[k][l] <= q_in[l] | (15'd1 << B);
					end else begin
						sc_rem_s[k][l] <= rem_in[l];
						sc_q_s[k][l] <= q_in[l];
					end
				end
			end
		end
	end

	// output register
	item_t fin_c;
	logic [1:0][15:0] ax_c;
	logic blank_c;
	assign fin_c = sc_it_s[QB-1];
	assign blank_c = fin_c.dead | fin_c.zero;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			logic [15:0] r;
			r = {1'b0, fin_c.asat[l] ? sdz_pkg::UNITY : sc_q_s[QB-1][l]};
			if (blank_c) begin
				ax_c[l] = '0;
			end else if (fin_c.neg[l]) begin
				ax_c[l] = 16'd0 - r;
			end else begin
				ax_c[l] = r;
			end
		end
	end

	sdz_pkg::rsp_t rsp_q;
	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q.out_x <= ax_c[0];
			rsp_q.out_y <= ax_c[1];
			rsp_q.out_magnitude <= blank_c ? '0 : fin_c.om;
			rsp_q.in_deadzone <= fin_c.dead;
		end
	end
	assign rsp = rsp_q;

	a_dead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.in_deadzone |->
			rsp.out_x == 16'sd0 && rsp.out_y == 16'sd0 && rsp.out_magnitude == 15'd0)
		else $error("deadzone response with non-zero outputs");

	a_mag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.out_magnitude == 15'd0 |-> rsp.out_x == 16'sd0 && rsp.out_y == 16'sd0)
		else $error("zero magnitude with non-zero axis");

	a_axis_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.out_x != 16'sh8000 && rsp.out_y != 16'sh8000)
		else $error("axis output beyond unity");
endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for stick_radial_deadzone.
// Drives stick requests with bursty flow and random response stalls, checks each
// response against a built-in deadzone predictor or a typed expected value; depends on sdz_pkg.
`timescale 1ns / 1ps
module testbench;
	localparam int AXIS_BITS = 16;
	localparam longint FS = (64'd1 << (AXIS_BITS - 1)) - 1;
	localparam int DRAIN_CYCLES = 100;

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		bit typed;
		sdz_pkg::rsp_t rsp;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	sdz_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	sdz_pkg::rsp_t rsp;
	logic cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;

	logic [15:0] dz_now = sdz_pkg::DZ_RESET;
	sdz_pkg::rsp_t conditioned_q[$];
	row_t typed_q[$];
	bit directed_on = 1'b0;
	int fail_cnt = 0;
	int hold_left = 0;

	stick_radial_deadzone #(.AXIS_BITS(AXIS_BITS)) uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #10 clk = ~clk;

	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic longint norm_axis(logic signed [15:0] raw);
		longint v;
		longint m;
		v = raw;
		if (v > FS) v = FS;
		if (v < -FS) v = -FS;
		m = (v < 0) ? -v : v;
		m = (m * 32767) / FS;
		return (v < 0) ? -m : m;
	endfunction

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned root;
		longint unsigned b;
		root = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= root + b) begin
				v -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	function automatic logic signed [15:0] scale_dir(longint n, longint unsigned om,
			longint unsigned s);
		longint unsigned a;
		longint unsigned r;
		a = (n < 0) ? -n : n;
		r = (a * om * 256) / s;
		if (r > 32767) r = 32767;
		return (n < 0) ? -r[15:0] : r[15:0];
	endfunction

	function automatic sdz_pkg::rsp_t condition_stick(sdz_pkg::req_t r, logic [15:0] dz);
		longint nx;
		longint ny;
		longint unsigned m2;
		longint unsigned thr;
		longint unsigned s;
		longint unsigned num;
		longint unsigned sub;
		longint unsigned om;
		sdz_pkg::rsp_t o;
		o = '0;
		nx = norm_axis(r.stick_x);
		ny = norm_axis(r.stick_y);
		m2 = nx * nx + ny * ny;
		thr = longint'(dz) * 32767;
		if ((m2 << 32) < thr * thr) begin
			o.in_deadzone = 1'b1;
			return o;
		end
		s = root_floor(m2 << 16);
		if (s == 0) return o;
		num = s * 256;
		sub = 32767 * longint'(dz);
		num = (num > sub) ? num - sub : 0;
		om = num / (65536 - longint'(dz));
		if (om > 32767) om = 32767;
		o.out_x = scale_dir(nx, om, s);
		o.out_y = scale_dir(ny, om, s);
		o.out_magnitude = om[14:0];
		return o;
	endfunction

	// request acceptance and response checking
	always @(posedge clk) begin
		sdz_pkg::rsp_t e;
		row_t row;
		if (req_valid && req_ready) begin
			e = condition_stick(req, dz_now);
			if (directed_on && typed_q.size() > 0) begin
				row = typed_q.pop_front();
				if (row.typed) e = row.rsp;
			end
			conditioned_q.push_back(e);
		end
		if (rsp_valid && rsp_ready) begin
			if (conditioned_q.size() == 0) begin
				$error("response with nothing expected");
				fail_cnt++;
			end else begin
				e = conditioned_q.pop_front();
				if (rsp.out_x !== e.out_x) begin
					$error("out_x exp %0d got %0d", e.out_x, rsp.out_x);
					fail_cnt++;
				end
				if (rsp.out_y !== e.out_y) begin
					$error("out_y exp %0d got %0d", e.out_y, rsp.out_y);
					fail_cnt++;
				end
				if (rsp.out_magnitude !== e.out_magnitude) begin
					$error("out_magnitude exp %0d got %0d", e.out_magnitude,
						rsp.out_magnitude);
					fail_cnt++;
				end
				if (rsp.in_deadzone !== e.in_deadzone) begin
					$error("in_deadzone exp %0d got %0d", e.in_deadzone, rsp.in_deadzone);
					fail_cnt++;
				end
			end
		end
	end

	// receiver stalls: own pattern, plus long hold-off on demand
	always @(negedge clk) begin
		int mode;
		int left;
		if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else begin
			if (left <= 0) begin
				mode = $urandom_range(3);
				left = $urandom_range(120, 8);
			end
			left--;
			case (mode)
				0: rsp_ready <= 1'b1;
				1: rsp_ready <= $urandom_range(1);
				2: rsp_ready <= ($urandom_range(3) == 0);
				default: rsp_ready <= ($urandom_range(7) != 0);
			endcase
		end
	end

	task automatic drain();
		wait (conditioned_q.size() == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_dz(logic [15:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		dz_now = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// valid held until accepted; caller decides on a gap afterwards
	task automatic send_request(logic signed [15:0] x, logic signed [15:0] y);
		req <= '{stick_x: x, stick_y: y};
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
	endtask

	task automatic idle_gap(int n);
		if (n > 0) begin
			req_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	function automatic logic signed [15:0] pick_axis(int rim);
		int r;
		r = $urandom_range(9);
		if (r < 4) return 16'($urandom());
		if (r == 4) return 16'sh7FFF;
		if (r == 5) return 16'sh8000;
		if (r == 6) return '0;
		if (r == 7) return $urandom_range(1) ? 16'sd1 : -16'sd1;
		r = $urandom_range(rim + rim / 4);
		return 16'($urandom_range(1) ? r : -r);
	endfunction

	task automatic random_phase(int n, bit squeeze);
		int burst;
		int rim;
		burst = 0;
		rim = (int'(dz_now) * 32767) >> 16;
		if (rim < 16) rim = 16;
		for (int i = 0; i < n; i++) begin
			if (squeeze && i == 5) hold_left = 400;
			if (i == n / 2 && $urandom_range(1)) begin
				req_valid <= 1'b0;
				drain();
			end
			send_request(pick_axis(rim), pick_axis(rim));
			if (burst <= 0) begin
				burst = $urandom_range(25, 1);
				idle_gap(squeeze ? 0 : $urandom_range(8));
			end
			burst--;
		end
		req_valid <= 1'b0;
	endtask

	initial begin
		row_t rows[$];
		logic [15:0] dz_set[$];
		rows = '{
			'{16'sd0, 16'sd0, 1'b1, '{16'sd0, 16'sd0, 15'd0, 1'b1}},
			'{16'sh7FFF, 16'sd0, 1'b1, '{16'sh7FFF, 16'sd0, 15'h7FFF, 1'b0}},
			'{16'sh8000, 16'sd0, 1'b1, '{-16'sh7FFF, 16'sd0, 15'h7FFF, 1'b0}},
			'{16'sd0, 16'sh8000, 1'b1, '{16'sd0, -16'sh7FFF, 15'h7FFF, 1'b0}},
			'{16'sd1, 16'sd0, 1'b1, '{16'sd0, 16'sd0, 15'd0, 1'b1}},
			'{16'sh7FFF, 16'sh7FFF, 1'b0, '0},
			'{16'sh8000, 16'sh8000, 1'b0, '0},
			'{16'sh7FFF, 16'sh8000, 1'b0, '0},
			'{16'sd7863, 16'sd0, 1'b0, '0},
			'{16'sd7864, 16'sd0, 1'b0, '0},
			'{16'sd7865, 16'sd0, 1'b0, '0},
			'{-16'sd5561, 16'sd5561, 1'b0, '0},
			'{16'sd12000, -16'sd3000, 1'b0, '0},
			'{16'sh5555, 16'sh2AAA, 1'b0, '0},
			'{-16'sd1, -16'sd1, 1'b0, '0},
			'{16'sd0, 16'sd20000, 1'b0, '0}
		};
		dz_set = '{16'd0, 16'hFFFF, 16'h8000, 16'd1, 16'($urandom),
			16'($urandom_range(20000)), sdz_pkg::DZ_RESET};
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// reset value of the deadzone register first
		directed_on = 1'b1;
		foreach (rows[i]) typed_q.push_back(rows[i]);
		foreach (rows[i]) begin
			send_request(rows[i].x, rows[i].y);
			idle_gap($urandom_range(2));
		end
		req_valid <= 1'b0;
		drain();
		directed_on = 1'b0;

		foreach (dz_set[i]) begin
			write_dz(dz_set[i]);
			if (dz_set[i] == 16'd0) begin
				send_request(16'sd0, 16'sd0);
				req_valid <= 1'b0;
			end
			random_phase(105, i == 2);
			drain();
		end

		if (conditioned_q.size() != 0) begin
			$error("%0d responses never arrived", conditioned_q.size());
			fail_cnt++;
		end
		if (fail_cnt == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

// ===== stick_radial_deadzone.f =====
design/sdz_pkg.sv
design/stick_radial_deadzone.sv
test/testbench.sv
